// ===== src/trimmed_mean_adc_filter_macros.svh =====
// Assertion macros used by the checker in tmf_checker.sv.
`ifndef TRIMMED_MEAN_ADC_FILTER_MACROS_SVH
`define TRIMMED_MEAN_ADC_FILTER_MACROS_SVH

// Same-cycle implication, off during reset.
`define TMF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off during reset.
`define TMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Implication that is checked during reset as well.
`define TMF_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/tmf_pkg.sv =====
`default_nettype none

package tmf_pkg;

    localparam int SAMPLE_BITS  = 8;
    localparam int WINDOW       = 30;
    localparam int TRIM         = 3;
    localparam int KEEP         = WINDOW - 2 * TRIM;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
    localparam int SUM_BOUND    = KEEP * SAMPLE_MAX;
    localparam int SUM_BITS     = $clog2(SUM_BOUND + 1);
    localparam int CNT_BITS     = $clog2(WINDOW);

    localparam int GAIN_BITS    = 24;
    localparam int FRAC_BITS    = 16;
    localparam int PROD_BITS    = SUM_BITS + GAIN_BITS;
    localparam int SHIFT_BITS   = PROD_BITS - FRAC_BITS;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 24'd742092;

    localparam int TRIMMED_BITS = 13;
    localparam int SCALED_BITS  = 21;
    localparam int TRIMMED_MAX  = 8191;
    localparam int SCALED_MAX   = 2097151;

    // APB map: one 32-bit register per word
    localparam int DATA_BITS    = 32;
    localparam int ADDR_BITS    = 3;
    localparam logic [ADDR_BITS-3:0] REG_GAIN = 1'b0;

    typedef struct packed {
        logic insert;    // sample word accepted
        logic complete;  // this word closes the window
        logic shift;     // snapshot row moves one cell on
    } tmf_ctl_t;

    function automatic logic [TRIMMED_BITS-1:0] sat_sum(input logic [SUM_BITS-1:0] s);
        logic [31:0] wide;
        wide = 32'(s);
        if (wide > 32'(TRIMMED_MAX))
            return TRIMMED_BITS'(TRIMMED_MAX);
        return wide[TRIMMED_BITS-1:0];
    endfunction

    function automatic logic [SCALED_BITS-1:0] sat_scaled(input logic [SHIFT_BITS-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        if (wide > 32'(SCALED_MAX))
            return SCALED_BITS'(SCALED_MAX);
        return wide[SCALED_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/tmf_cell.sv =====
`default_nettype none

// One slot of the sorted row plus one slot of the drain snapshot.
module tmf_cell (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire tmf_pkg::tmf_ctl_t               ctl,
    input  wire logic [tmf_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic                            prev_gt,
    input  wire logic                            prev_valid,
    input  wire logic [tmf_pkg::SAMPLE_BITS-1:0] prev_val,
    input  wire logic [tmf_pkg::SAMPLE_BITS-1:0] prev_snap,
    output logic                                 gt,
    output logic                                 valid,
    output logic [tmf_pkg::SAMPLE_BITS-1:0]      val,
    output logic [tmf_pkg::SAMPLE_BITS-1:0]      snap
);

    logic                            valid_reg;
    logic                            valid_next;
    logic [tmf_pkg::SAMPLE_BITS-1:0] val_reg;
    logic [tmf_pkg::SAMPLE_BITS-1:0] val_next;
    logic [tmf_pkg::SAMPLE_BITS-1:0] snap_reg;
    logic [tmf_pkg::SAMPLE_BITS-1:0] snap_next;
    logic [tmf_pkg::SAMPLE_BITS-1:0] ins_val;

    // empty slot behaves as +inf; equal keeps arrival order
    assign gt      = !valid_reg || (val_reg > sample);
    assign ins_val = prev_gt ? prev_val : (gt ? sample : val_reg);

    always_comb
    begin
        valid_next = valid_reg;
        val_next   = val_reg;
        snap_next  = snap_reg;
        if (ctl.insert)
        begin
            if (ctl.complete)
            begin
                valid_next = 1'b0;
                snap_next  = ins_val;
            end
            else
            begin
                valid_next = valid_reg || prev_valid;
                val_next   = ins_val;
            end
        end
        if (ctl.shift)
            snap_next = prev_snap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        snap_reg <= snap_next;
    end

    assign valid = valid_reg;
    assign val   = val_reg;
    assign snap  = snap_reg;

endmodule

`default_nettype wire

// ===== src/tmf_scaler.sv =====
`default_nettype none

// Sum hold, gain multiply, saturate, output word register.
module tmf_scaler (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             sum_valid,
    input  wire logic [tmf_pkg::SUM_BITS-1:0]     sum,
    input  wire logic [tmf_pkg::GAIN_BITS-1:0]    gain,
    input  wire logic                             result_stall,
    output logic                                  result_valid,
    output logic [tmf_pkg::TRIMMED_BITS-1:0]      trimmed_sum,
    output logic [tmf_pkg::SCALED_BITS-1:0]       scaled_value,
    output logic                                  busy
);

    logic                              p1_reg;
    logic                              p1_next;
    logic [tmf_pkg::SUM_BITS-1:0]      sum_reg;
    logic                              p2_reg;
    logic                              p2_next;
    logic [tmf_pkg::SUM_BITS-1:0]      sum2_reg;
    logic [tmf_pkg::PROD_BITS-1:0]     prod_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [tmf_pkg::TRIMMED_BITS-1:0]  trimmed_reg;
    logic [tmf_pkg::SCALED_BITS-1:0]   scaled_reg;
    logic                              move_out;
    logic                              move_p2;

    assign move_out = p2_reg && (!out_valid_reg || !result_stall);
    assign move_p2  = p1_reg && (!p2_reg || move_out);

    always_comb
    begin
        p1_next        = (p1_reg && !move_p2) || sum_valid;
        p2_next        = (p2_reg && !move_out) || move_p2;
        out_valid_next = move_out || (out_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_valid)
            sum_reg <= sum;
        if (move_p2)
        begin
            sum2_reg <= sum_reg;
            prod_reg <= tmf_pkg::PROD_BITS'(sum_reg) * tmf_pkg::PROD_BITS'(gain);
        end
        if (move_out)
        begin
            trimmed_reg <= tmf_pkg::sat_sum(sum2_reg);
            scaled_reg  <= tmf_pkg::sat_scaled(prod_reg[tmf_pkg::PROD_BITS-1:tmf_pkg::FRAC_BITS]);
        end
    end

    assign busy         = p1_reg || p2_reg || out_valid_reg;
    assign result_valid = out_valid_reg;
    assign trimmed_sum  = trimmed_reg;
    assign scaled_value = scaled_reg;

endmodule

`default_nettype wire

// ===== src/trimmed_mean_adc_filter.sv =====
`default_nettype none

// Trimmed-mean filter for a converter sample stream.
// Input channel: sample with sample_valid / sample_stall; one word per clock unless stalled.
// Each word is dropped into a row of WINDOW (30) cells kept in ascending order.
// The word that fills the window copies the row into a snapshot and empties the
// row, so the next window starts filling on the following clock.
// The snapshot shifts out one cell per clock into an accumulator that keeps the
// middle 24 values (3 dropped at either end).
// Output channel: trimmed_sum and scaled_value with result_valid / result_stall;
// scaled_value = (trimmed_sum * gain) >> 16, saturated.
// Once the drain ends, the sum goes through the multiply and the output register.
// Throughput: one word per clock within a window; the closing word waits for the
// drain and the result handoff, so one window is through before the next closes.
// A stalled result holds; sample_stall is raised only on the closing word while
// the previous window is still draining or its result is still undelivered.
// Reset empties the row, clears all flags and loads gain with 742092.
// APB: gain at byte address 0 (24 bits), pready tied high.
module trimmed_mean_adc_filter (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // sample channel
    input  wire logic                                 sample_valid,
    output logic                                      sample_stall,
    input  wire logic [7:0]                           sample,
    // result channel
    output logic                                      result_valid,
    input  wire logic                                 result_stall,
    output logic [tmf_pkg::TRIMMED_BITS-1:0]          trimmed_sum,
    output logic [tmf_pkg::SCALED_BITS-1:0]           scaled_value,
    // APB
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [tmf_pkg::ADDR_BITS-1:0]        paddr,
    input  wire logic [tmf_pkg::DATA_BITS-1:0]        pwdata,
    output logic [tmf_pkg::DATA_BITS-1:0]             prdata,
    output logic                                      pready
);

    localparam int SB = tmf_pkg::SAMPLE_BITS;
    localparam int W  = tmf_pkg::WINDOW;

    // config
    logic [tmf_pkg::GAIN_BITS-1:0] gain_reg;
    logic [tmf_pkg::GAIN_BITS-1:0] gain_next;
    logic                          cfg_write;
    logic                          gain_hit;

    assign pready    = 1'b1;
    assign gain_hit  = (paddr[tmf_pkg::ADDR_BITS-1:2] == tmf_pkg::REG_GAIN);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        gain_next = gain_reg;
        if (cfg_write && gain_hit)
            gain_next = pwdata[tmf_pkg::GAIN_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= tmf_pkg::GAIN_RESET;
        else
            gain_reg <= gain_next;
    end

    assign prdata = gain_hit ? tmf_pkg::DATA_BITS'(gain_reg) : '0;

    // fill count and handshake
    logic [tmf_pkg::CNT_BITS-1:0] fill_reg;
    logic [tmf_pkg::CNT_BITS-1:0] fill_next;
    logic                         last_word;
    logic                         accept;
    logic                         scaler_busy;
    logic                         busy_reg;
    logic                         busy_next;
    tmf_pkg::tmf_ctl_t            ctl;

    assign last_word    = (fill_reg == tmf_pkg::CNT_BITS'(W - 1));
    // closing word waits until the drain path is free
    assign sample_stall = last_word && (busy_reg || scaler_busy);
    assign accept       = sample_valid && !sample_stall;

    assign ctl.insert   = accept;
    assign ctl.complete = last_word;
    assign ctl.shift    = busy_reg;

    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
            fill_next = last_word ? '0 : fill_reg + 1'b1;
    end

    // sorted row
    logic          gt_w    [W+1];
    logic          valid_w [W+1];
    logic [SB-1:0] val_w   [W+1];
    logic [SB-1:0] snap_w  [W+1];

    // left boundary: never greater, always occupied
    assign gt_w[0]    = 1'b0;
    assign valid_w[0] = 1'b1;
    assign val_w[0]   = '0;
    assign snap_w[0]  = '0;

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        tmf_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .sample     (sample[SB-1:0]),
            .prev_gt    (gt_w[i]),
            .prev_valid (valid_w[i]),
            .prev_val   (val_w[i]),
            .prev_snap  (snap_w[i]),
            .gt         (gt_w[i+1]),
            .valid      (valid_w[i+1]),
            .val        (val_w[i+1]),
            .snap       (snap_w[i+1])
        );
    end

    // drain: cell W-1 leaves first, so count k sees sorted index W-1-k
    logic [tmf_pkg::CNT_BITS-1:0] cnt_reg;
    logic [tmf_pkg::CNT_BITS-1:0] cnt_next;
    logic [tmf_pkg::SUM_BITS-1:0] acc_reg;
    logic [tmf_pkg::SUM_BITS-1:0] acc_next;
    logic [tmf_pkg::SUM_BITS-1:0] term;
    logic                         keep;
    logic                         drain_done;

    assign keep = (cnt_reg >= tmf_pkg::CNT_BITS'(tmf_pkg::TRIM))
               && (cnt_reg <= tmf_pkg::CNT_BITS'(W - 1 - tmf_pkg::TRIM));
    assign term       = keep ? tmf_pkg::SUM_BITS'(snap_w[W]) : '0;
    assign drain_done = busy_reg && (cnt_reg == tmf_pkg::CNT_BITS'(W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        if (accept && last_word)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + term;
            cnt_next = cnt_reg + 1'b1;
            if (drain_done)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    tmf_scaler u_scaler (
        .clk          (clk),
        .rst_n        (rst_n),
        .sum_valid    (drain_done),
        .sum          (acc_next),
        .gain         (gain_reg),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .trimmed_sum  (trimmed_sum),
        .scaled_value (scaled_value),
        .busy         (scaler_busy)
    );

endmodule

`default_nettype wire

// ===== src/tmf_checker.sv =====
`default_nettype none

`include "trimmed_mean_adc_filter_macros.svh"

module tmf_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 result_valid,
    input wire logic                                 result_stall,
    input wire logic [tmf_pkg::TRIMMED_BITS-1:0]     trimmed_sum,
    input wire logic [tmf_pkg::SCALED_BITS-1:0]      scaled_value,
    input wire logic                                 pready
);

    `TMF_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && result_stall, result_valid)
    `TMF_ASSERT_NEXT(a_result_stable, clk, rst_n, result_valid && result_stall, $stable(trimmed_sum) && $stable(scaled_value))
    `TMF_ASSERT_IMPLY(a_sum_bound, clk, rst_n, result_valid, 32'(trimmed_sum) <= 32'(tmf_pkg::SUM_BOUND))
    `TMF_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n, !result_valid && pready)

endmodule

bind trimmed_mean_adc_filter tmf_checker u_tmf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .trimmed_sum  (trimmed_sum),
    .scaled_value (scaled_value),
    .pready       (pready)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // Run bounds.  A result shows only after the drain and the scaler registers, so
    // DRAIN_CYCLES of quiet covers them with some slack.
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_WORDS = 480;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [tmf_pkg::ADDR_BITS-1:0] GAIN_ADDR = {tmf_pkg::REG_GAIN, 2'b00};

    // Sample patterns for one window's worth of words
    typedef enum logic [2:0] {
        SHAPE_CONST,
        SHAPE_RAMP_UP,
        SHAPE_RAMP_DOWN,
        SHAPE_SPIKES,     // three lows and three highs among a flat level
        SHAPE_OUTLIERS,   // five lows and five highs among a flat level
        SHAPE_TIES,       // three distinct values, heavily repeated
        SHAPE_NOISE,      // full-range uniform
        SHAPE_BAND        // narrow band round a level, occasional rail hits
    } shape_t;

    typedef struct {
        logic [tmf_pkg::TRIMMED_BITS-1:0] trimmed;
        logic [tmf_pkg::SCALED_BITS-1:0]  scaled;
    } window_result_t;

    // Directed window: pattern, optional gain write beforehand, optional hand-typed result
    typedef struct packed {
        shape_t                           shape;
        logic [tmf_pkg::SAMPLE_BITS-1:0]  level;
        logic                             reprogram;
        logic [tmf_pkg::DATA_BITS-1:0]    gain_word;
        logic                             typed;
        logic [tmf_pkg::TRIMMED_BITS-1:0] sum_typed;
        logic [tmf_pkg::SCALED_BITS-1:0]  scaled_typed;
    } window_row_t;

    localparam int DIR_ROWS = 9;

    window_row_t dir_rows [DIR_ROWS] = '{
        // all zero at reset gain
        '{SHAPE_CONST,     8'd0,   1'b0, 32'd0,          1'b1, 13'd0,    21'd0},
        // full scale at reset gain: 6120 * 742092 >> 16
        '{SHAPE_CONST,     8'd255, 1'b0, 32'd0,          1'b1, 13'd6120, 21'd69299},
        // top gain, bits above 24 must be dropped
        '{SHAPE_CONST,     8'd255, 1'b1, 32'hFFFF_FFFF,  1'b1, 13'd6120, 21'd1566719},
        // zero gain
        '{SHAPE_CONST,     8'd255, 1'b1, 32'd0,          1'b1, 13'd6120, 21'd0},
        // exactly the trimmed count of outliers, charge-current gain
        '{SHAPE_SPIKES,    8'd100, 1'b1, 32'd88347,      1'b1, 13'd2400, 21'd3235},
        '{SHAPE_RAMP_UP,   8'd0,   1'b1, 32'd742092,     1'b0, 13'd0,    21'd0},
        '{SHAPE_RAMP_DOWN, 8'd255, 1'b0, 32'd0,          1'b0, 13'd0,    21'd0},
        '{SHAPE_TIES,      8'd7,   1'b0, 32'd0,          1'b0, 13'd0,    21'd0},
        // more outliers than trimmed, unity gain
        '{SHAPE_OUTLIERS,  8'd128, 1'b1, 32'h0001_0000,  1'b0, 13'd0,    21'd0}
    };

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              sample_valid;
    logic                              sample_stall;
    logic [7:0]                        sample;
    logic                              result_valid;
    logic                              result_stall = 1'b0;
    logic [tmf_pkg::TRIMMED_BITS-1:0]  trimmed_sum;
    logic [tmf_pkg::SCALED_BITS-1:0]   scaled_value;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [tmf_pkg::ADDR_BITS-1:0]     paddr;
    logic [tmf_pkg::DATA_BITS-1:0]     pwdata;
    logic [tmf_pkg::DATA_BITS-1:0]     prdata;
    logic                              pready;

    // Shadow of the block: sorted window, fill level, gain
    logic [tmf_pkg::SAMPLE_BITS-1:0]   ordered [tmf_pkg::WINDOW];
    int                                held;
    logic [tmf_pkg::GAIN_BITS-1:0]     gain_model;

    window_result_t           pending_windows [$];
    bit                       typed_armed;
    window_result_t           typed_result;

    bit                       steady;        // no idling on either side while set
    int                       mismatches;
    int                       cycles;

    trimmed_mean_adc_filter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .trimmed_sum  (trimmed_sum),
        .scaled_value (scaled_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side back-pressure: roughly 30% of clocks, none during the steady stretch
    always @(posedge clk)
        result_stall <= !steady && ($urandom_range(99) < 30);

    // Insert one accepted word into the shadow window; on the closing word work out
    // the trimmed sum and the scaled value, then empty the window.
    task automatic fold_sample(input logic [tmf_pkg::SAMPLE_BITS-1:0] v);
        int             pos;
        logic [31:0]    sum;
        logic [63:0]    prod;
        window_result_t r;
        pos = held;
        // ties keep arrival order: only strictly larger entries move up
        while (pos > 0 && ordered[pos-1] > v)
        begin
            ordered[pos] = ordered[pos-1];
            pos--;
        end
        ordered[pos] = v;
        held++;
        if (held == tmf_pkg::WINDOW)
        begin
            sum = 0;
            for (int k = tmf_pkg::TRIM; k < tmf_pkg::WINDOW - tmf_pkg::TRIM; k++)
                sum += 32'(ordered[k]);
            prod = (64'(sum) * 64'(gain_model)) >> tmf_pkg::FRAC_BITS;
            r.trimmed = (sum > 32'(tmf_pkg::TRIMMED_MAX))
                      ? tmf_pkg::TRIMMED_BITS'(tmf_pkg::TRIMMED_MAX)
                      : tmf_pkg::TRIMMED_BITS'(sum);
            r.scaled  = (prod > 64'(tmf_pkg::SCALED_MAX))
                      ? tmf_pkg::SCALED_BITS'(tmf_pkg::SCALED_MAX)
                      : tmf_pkg::SCALED_BITS'(prod);
            if (typed_armed)
            begin
                r = typed_result;
                typed_armed = 1'b0;
            end
            pending_windows.push_back(r);
            held = 0;
        end
    endtask

    function automatic logic [7:0] shaped_sample(input shape_t shape,
                                                 input logic [7:0] level,
                                                 input int idx);
        logic [7:0] v;
        case (shape)
            SHAPE_CONST:     v = level;
            SHAPE_RAMP_UP:   v = level + 8'(idx);
            SHAPE_RAMP_DOWN: v = level - 8'(idx);
            SHAPE_SPIKES:    v = (idx % 5 != 0) ? level : (((idx / 5) % 2) ? 8'hFF : 8'h00);
            SHAPE_OUTLIERS:  v = (idx % 3 != 0) ? level : (((idx / 3) % 2) ? 8'hFF : 8'h00);
            SHAPE_TIES:      v = level + 8'(idx % 3);
            SHAPE_BAND:
                if ($urandom_range(9) == 0)
                    v = $urandom_range(1) ? 8'hFF : 8'h00;
                else
                    v = level + 8'($urandom_range(6)) - 8'd3;
            default:         v = 8'($urandom_range(255));
        endcase
        return v;
    endfunction

    // One sample word; an optional gap first, then hold until accepted.
    // Valid is left high on return so back-to-back words run without a bubble.
    task automatic send_word(input logic [7:0] v);
        if (!steady && $urandom_range(99) < 30)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= v;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        fold_sample(v);
    endtask

    // Drop valid, wait for every outstanding result, then let the drain finish
    task automatic settle();
        sample_valid <= 1'b0;
        while (pending_windows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Gain write followed straight away by a read-back (psel stays up between them)
    task automatic program_gain(input logic [tmf_pkg::DATA_BITS-1:0] word);
        logic [tmf_pkg::DATA_BITS-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= GAIN_ADDR;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        gain_model = word[tmf_pkg::GAIN_BITS-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== tmf_pkg::DATA_BITS'(gain_model))
        begin
            $error("gain: expected %0d, got %0d", gain_model, got);
            mismatches++;
        end
    endtask

    // Result checker: each accepted result against the oldest expectation
    always @(posedge clk)
    begin : result_check
        window_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_windows.size() == 0)
            begin
                $error("result with nothing expected: trimmed_sum %0d, scaled_value %0d",
                       trimmed_sum, scaled_value);
                mismatches++;
            end
            else
            begin
                want = pending_windows.pop_front();
                if (trimmed_sum !== want.trimmed)
                begin
                    $error("trimmed_sum: expected %0d, got %0d", want.trimmed, trimmed_sum);
                    mismatches++;
                end
                if (scaled_value !== want.scaled)
                begin
                    $error("scaled_value: expected %0d, got %0d", want.scaled, scaled_value);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int               n;
        int               sent;
        shape_t           shape;
        logic [7:0]       level;
        logic [31:0]      word;

        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        cycles       = 0;
        mismatches   = 0;
        steady       = 1'b0;
        typed_armed  = 1'b0;
        held         = 0;
        gain_model   = tmf_pkg::GAIN_RESET;
        shape        = SHAPE_NOISE;
        level        = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed windows, each a full 30 words so every row closes its own window
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].reprogram)
            begin
                settle();
                program_gain(dir_rows[r].gain_word);
            end
            typed_armed          = dir_rows[r].typed;
            typed_result.trimmed = dir_rows[r].sum_typed;
            typed_result.scaled  = dir_rows[r].scaled_typed;
            for (int i = 0; i < tmf_pkg::WINDOW; i++)
                send_word(shaped_sample(dir_rows[r].shape, dir_rows[r].level, i));
        end

        // Random phases.  Phase lengths need not be window multiples, so partly filled
        // windows can carry across the gain writes.
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            settle();
            case ($urandom_range(5))
                0:       word = 32'd0;
                1:       word = 32'hFFFF_FFFF;
                2:       word = 32'd742092;
                3:       word = 32'd88347;
                default: word = $urandom;
            endcase
            program_gain(word);
            n = $urandom_range(150, 40);
            for (int i = 0; i < n; i++)
            begin
                if (i % tmf_pkg::WINDOW == 0)
                begin
                    shape = shape_t'($urandom_range(7));
                    level = 8'($urandom_range(255));
                end
                steady = (sent >= 200 && sent < 400);
                send_word(shaped_sample(shape, level, i % tmf_pkg::WINDOW));
                sent++;
            end
        end
        steady = 1'b0;

        settle();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/tmf_pkg.sv
src/tmf_cell.sv
src/tmf_scaler.sv
src/trimmed_mean_adc_filter.sv
src/tmf_checker.sv
tb/tb_top.sv
